@@ rtl/uart_register_datagram_crc8_macros.svh @@
// Assertion macros for the register link RTL (included by urdc_back).
`ifndef UART_REGISTER_DATAGRAM_CRC8_MACROS_SVH
`define UART_REGISTER_DATAGRAM_CRC8_MACROS_SVH

// Check a property on a given clock, off while the given active-low reset is low.
`define URDC_ASSERT_ON(label, clock, reset_n, prop, msg) \
  label: assert property (@(posedge clock) disable iff (!reset_n) (prop)) else $error(msg);

// Check a property on the module's own clk and rst_n.
`define URDC_ASSERT(label, prop, msg) `URDC_ASSERT_ON(label, clk, rst_n, prop, msg)

`endif

@@ rtl/urdc_pkg.sv @@
// Types, constants and the CRC-8 step shared by the register link modules.
package urdc_pkg;

  // Request codes on the input channel
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_RX    = 2'd2;

  // Result kinds
  localparam logic RESULT_TX    = 1'b0;
  localparam logic RESULT_REPLY = 1'b1;

  localparam logic [7:0] SyncByte     = 8'h05;
  localparam logic [7:0] CrcPoly      = 8'h07;
  localparam logic [7:0] CrcInit      = 8'h00;
  localparam logic [7:0] ReplyAddress = 8'hFF;

  // Byte positions inside frames
  localparam logic [2:0] WriteLastPos    = 3'd7;
  localparam logic [2:0] ReadLastPos     = 3'd3;
  localparam logic [2:0] ReplyLastPos    = 3'd7;
  localparam logic [2:0] ReplyAddrPos    = 3'd1;
  localparam logic [2:0] ReplyPayloadPos = 3'd3;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_RX
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [6:0]  idx;
    logic [31:0] data;   // write value, or the received byte in the low bits
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [31:0] read_value;
    logic        reply_valid;
  } result_t;

  // Feed one byte, LSB first, into a left-shifting CRC-8 register
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      c = (c[7] ^ b[k]) ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

@@ rtl/uart_register_datagram_crc8.sv @@
// Top level of the UART register link master: framing, CRC-8 and reply checking.
//
// Input channel (push/full): one transaction is a write request, a read request
// or one received line byte (in_req_type 0, 1, 2; code 3 is taken and dropped).
// Result channel (empty/pop): the oldest result sits on the out_ ports while
// empty is low. A write request yields 8 transmit bytes (sync, node, index with
// bit 7 set, value MSB first, CRC), a read request 4 (sync, node, index, CRC);
// out_last marks the CRC byte. Every eighth received byte yields one reply
// result with out_read_value and out_reply_valid (address 0xFF and CRC match).
// Configuration: cfg_valid/cfg_ready writes node_address; cfg_ready is always
// high. Write it only while the block is idle.
// Path: a request is first registered in the queue; its first result is then loaded
// into the result register, if the queue was empty and the result register free.
// Throughput: the back end emits one frame byte per cycle while the result
// register is free or popped; the request queue lets the next items enter
// while a frame is being sent. A stalled receiver (pop low) holds the result
// register and the back end waits, though received bytes other than every eighth
// still go in; full rises once the request queue is full. Reset clears the queue,
// the reply assembly state, the result valid flag and node_address.
module uart_register_datagram_crc8 import urdc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_req_type,
  input  logic [6:0]  in_reg_index,
  input  logic [31:0] in_write_data,
  input  logic [7:0]  in_rx_byte,
  // result channel
  output logic        empty,
  input  logic        pop,
  output logic        out_result_kind,
  output logic [7:0]  out_tx_byte,
  output logic        out_last,
  output logic [31:0] out_read_value,
  output logic        out_reply_valid,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_node_address
);

  logic [7:0] node_address_r;
  head_t      head;
  logic       head_pop;
  logic       out_valid;
  result_t    result;

  // Node address, always ready; the user must make writes only while idle (unchecked)
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_address_r <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      node_address_r <= cfg_node_address;
    end
  end

  // Accept and classify requests; queue them in arrival order
  urdc_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .req_type   (in_req_type),
    .reg_index  (in_reg_index),
    .write_data (in_write_data),
    .rx_byte    (in_rx_byte),
    .head       (head),
    .head_pop   (head_pop)
  );

  // Serialize frames and assemble replies into the result register
  urdc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .node_address (node_address_r),
    .head         (head),
    .head_pop     (head_pop),
    .out_pop      (pop),
    .out_valid    (out_valid),
    .result       (result)
  );

  assign empty           = !out_valid;
  assign out_result_kind = result.result_kind;
  assign out_tx_byte     = result.tx_byte;
  assign out_last        = result.last;
  assign out_read_value  = result.read_value;
  assign out_reply_valid = result.reply_valid;

endmodule

@@ rtl/urdc_front.sv @@
// Front end: accept requests, classify them and queue them for the back end.
module urdc_front import urdc_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  req_type,
  input  logic [6:0]  reg_index,
  input  logic [31:0] write_data,
  input  logic [7:0]  rx_byte,
  output head_t       head,
  input  logic        head_pop
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  entry_t            q_r [DEPTH];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   count_r, count_nxt;
  entry_t            entry_in;
  logic              keep;
  logic              wr_en;
  logic              rd_en;

  // Classify; drop the unused code
  always_comb begin
    entry_in.kind = CMD_RX;
    entry_in.idx  = reg_index;
    entry_in.data = write_data;
    keep          = 1'b1;
    unique case (req_type)
      REQ_WRITE: entry_in.kind = CMD_WRITE;
      REQ_READ:  entry_in.kind = CMD_READ;
      REQ_RX: begin
        entry_in.kind = CMD_RX;
        entry_in.data = {24'd0, rx_byte};
      end
      default: keep = 1'b0;
    endcase
  end

  assign full  = (count_r == CntW'(DEPTH));
  assign wr_en = push && !full && keep;
  assign rd_en = head_pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CntW'(wr_en) - CntW'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= entry_in;
    end
  end

  assign head.valid = (count_r != '0);
  assign head.entry = q_r[rd_ptr_r];

endmodule

@@ rtl/urdc_back.sv @@
// Back end: serialize frames with CRC, assemble replies, hold the result register.
module urdc_back import urdc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] node_address,
  input  head_t      head,
  output logic       head_pop,
  input  logic       out_pop,
  output logic       out_valid,
  output result_t    result
);

  `include "uart_register_datagram_crc8_macros.svh"

  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [2:0]  rx_count_r, rx_count_nxt;
  logic [7:0]  rx_crc_r, rx_crc_nxt;
  logic [7:0]  rx_addr_r, rx_addr_nxt;
  logic [31:0] rx_payload_r, rx_payload_nxt;
  logic        out_valid_r, out_valid_nxt;
  result_t     result_r, result_nxt;

  entry_t      e;
  logic        out_free;
  logic        go;
  logic        out_load;
  logic        frame_last;
  logic [7:0]  body_byte;
  logic [7:0]  rx_b;

  assign e        = head.entry;
  assign rx_b     = e.data[7:0];
  assign out_free = !out_valid_r || out_pop;
  assign go       = head.valid &&
                    (out_free || (e.kind == CMD_RX && rx_count_r != ReplyLastPos));
  assign frame_last = (e.kind == CMD_WRITE) ? (pos_r == WriteLastPos)
                                            : (pos_r == ReadLastPos);

  always_comb begin
    case (pos_r)
      3'd0:    body_byte = SyncByte;
      3'd1:    body_byte = node_address;
      3'd2:    body_byte = {(e.kind == CMD_WRITE), e.idx};
      3'd3:    body_byte = e.data[31:24];
      3'd4:    body_byte = e.data[23:16];
      3'd5:    body_byte = e.data[15:8];
      default: body_byte = e.data[7:0];
    endcase
  end

  always_comb begin
    pos_nxt        = pos_r;
    crc_nxt        = crc_r;
    rx_count_nxt   = rx_count_r;
    rx_crc_nxt     = rx_crc_r;
    rx_addr_nxt    = rx_addr_r;
    rx_payload_nxt = rx_payload_r;
    head_pop       = 1'b0;
    out_load       = 1'b0;
    result_nxt     = result_r;
    if (go) begin
      if (e.kind == CMD_RX) begin
        head_pop = 1'b1;
        if (rx_count_r == ReplyLastPos) begin
          out_load               = 1'b1;
          result_nxt.result_kind = RESULT_REPLY;
          result_nxt.tx_byte     = 8'd0;
          result_nxt.last        = 1'b0;
          result_nxt.read_value  = rx_payload_r;
          result_nxt.reply_valid = (rx_addr_r == ReplyAddress) && (rx_crc_r == rx_b);
          rx_count_nxt           = 3'd0;
          rx_crc_nxt             = CrcInit;
          rx_addr_nxt            = 8'd0;
          rx_payload_nxt         = 32'd0;
        end else begin
          rx_crc_nxt   = crc8_feed(rx_crc_r, rx_b);
          rx_count_nxt = rx_count_r + 3'd1;
          if (rx_count_r == ReplyAddrPos) begin
            rx_addr_nxt = rx_b;
          end
          if (rx_count_r >= ReplyPayloadPos) begin
            rx_payload_nxt = {rx_payload_r[23:0], rx_b};
          end
        end
      end else begin
        out_load               = 1'b1;
        result_nxt.result_kind = RESULT_TX;
        result_nxt.tx_byte     = frame_last ? crc_r : body_byte;
        result_nxt.last        = frame_last;
        result_nxt.read_value  = 32'd0;
        result_nxt.reply_valid = 1'b0;
        if (frame_last) begin
          head_pop = 1'b1;
          pos_nxt  = 3'd0;
          crc_nxt  = CrcInit;
        end else begin
          pos_nxt = pos_r + 3'd1;
          crc_nxt = crc8_feed(crc_r, body_byte);
        end
      end
    end
    out_valid_nxt = out_load || (out_valid_r && !out_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= 3'd0;
      crc_r        <= CrcInit;
      rx_count_r   <= 3'd0;
      rx_crc_r     <= CrcInit;
      rx_addr_r    <= 8'd0;
      rx_payload_r <= 32'd0;
      out_valid_r  <= 1'b0;
    end else begin
      pos_r        <= pos_nxt;
      crc_r        <= crc_nxt;
      rx_count_r   <= rx_count_nxt;
      rx_crc_r     <= rx_crc_nxt;
      rx_addr_r    <= rx_addr_nxt;
      rx_payload_r <= rx_payload_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

  `URDC_ASSERT(a_mid_frame_head, (pos_r != 3'd0) |-> (head.valid && e.kind != CMD_RX), "frame in progress without a request at the head")
  `URDC_ASSERT(a_write_len, (head_pop && e.kind == CMD_WRITE) |-> (pos_r == WriteLastPos), "write request retired before its eighth byte")
  `URDC_ASSERT(a_read_len, (head_pop && e.kind == CMD_READ) |-> (pos_r == ReadLastPos), "read request retired before its fourth byte")
  `URDC_ASSERT(a_no_overwrite, (out_valid_r && !out_pop) |=> $stable(result_r), "waiting result overwritten")

endmodule

@@ tb/sv/uart_register_datagram_crc8_checker.sv @@
// Checker for the UART register link: predicts frames and replies and compares results.
module uart_register_datagram_crc8_checker import urdc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  in_req_type,
  input  logic [6:0]  in_reg_index,
  input  logic [31:0] in_write_data,
  input  logic [7:0]  in_rx_byte,
  input  logic        empty,
  input  logic        pop,
  input  logic        out_result_kind,
  input  logic [7:0]  out_tx_byte,
  input  logic        out_last,
  input  logic [31:0] out_read_value,
  input  logic        out_reply_valid,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_node_address,
  output int          fail_count,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  result_t     awaited_q[$];
  logic [7:0]  node_addr;
  logic [2:0]  reply_pos;
  logic [7:0]  reply_crc;
  logic [7:0]  reply_addr;
  logic [31:0] reply_word;
  logic [7:0]  frame_body [0:6];
  int          errors;

  // CRC-8, poly 0x07, data taken LSB first into a left-shifting register
  function automatic logic [7:0] crc8_lsb_first(input logic [7:0] acc, input logic [7:0] din);
    logic fb;
    int   i;
    for (i = 0; i < 8; i++) begin
      fb  = acc[7] ^ din[i];
      acc = {acc[6:0], 1'b0};
      if (fb) acc = acc ^ CrcPoly;
    end
    return acc;
  endfunction

  task automatic expect_frame(input int len);
    result_t    r;
    logic [7:0] crc;
    int         i;
    crc = CrcInit;
    for (i = 0; i < len; i++) begin
      crc = crc8_lsb_first(crc, frame_body[i]);
      r = '0;
      r.result_kind = RESULT_TX;
      r.tx_byte     = frame_body[i];
      awaited_q.push_back(r);
    end
    r = '0;
    r.result_kind = RESULT_TX;
    r.tx_byte     = crc;
    r.last        = 1'b1;
    awaited_q.push_back(r);
  endtask

  task automatic predict_request();
    result_t r;
    case (in_req_type)
      REQ_WRITE: begin
        frame_body[0] = SyncByte;
        frame_body[1] = node_addr;
        frame_body[2] = {1'b1, in_reg_index};
        frame_body[3] = in_write_data[31:24];
        frame_body[4] = in_write_data[23:16];
        frame_body[5] = in_write_data[15:8];
        frame_body[6] = in_write_data[7:0];
        expect_frame(7);
      end
      REQ_READ: begin
        frame_body[0] = SyncByte;
        frame_body[1] = node_addr;
        frame_body[2] = {1'b0, in_reg_index};
        expect_frame(3);
      end
      REQ_RX: begin
        if (reply_pos != ReplyLastPos) begin
          reply_crc = crc8_lsb_first(reply_crc, in_rx_byte);
          if (reply_pos == ReplyAddrPos) reply_addr = in_rx_byte;
          else if (reply_pos >= ReplyPayloadPos) reply_word = {reply_word[23:0], in_rx_byte};
          reply_pos = reply_pos + 3'd1;
        end else begin
          r = '0;
          r.result_kind = RESULT_REPLY;
          r.read_value  = reply_word;
          r.reply_valid = (reply_addr == ReplyAddress) && (reply_crc == in_rx_byte);
          awaited_q.push_back(r);
          reply_pos  = '0;
          reply_crc  = CrcInit;
          reply_addr = '0;
          reply_word = '0;
        end
      end
      default: ;  // unused code: drop
    endcase
  endtask

  task automatic check_result();
    result_t got;
    result_t want;
    got.result_kind = out_result_kind;
    got.tx_byte     = out_tx_byte;
    got.last        = out_last;
    got.read_value  = out_read_value;
    got.reply_valid = out_reply_valid;
    if (awaited_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: kind %0d byte %02h last %0d value %08h valid %0d",
                 got.result_kind, got.tx_byte, got.last, got.read_value, got.reply_valid);
    end else begin
      want = awaited_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected kind %0d byte %02h last %0d value %08h valid %0d, got kind %0d byte %02h last %0d value %08h valid %0d",
                   want.result_kind, want.tx_byte, want.last, want.read_value,
                   want.reply_valid, got.result_kind, got.tx_byte, got.last,
                   got.read_value, got.reply_valid);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      awaited_q.delete();
      node_addr  = '0;
      reply_pos  = '0;
      reply_crc  = CrcInit;
      reply_addr = '0;
      reply_word = '0;
      errors     = 0;
    end else begin
      if (pop && !empty) check_result();
      if (push && !full) predict_request();
      if (cfg_valid && cfg_ready) node_addr = cfg_node_address;
    end
    outstanding <= awaited_q.size();
    fail_count  <= errors;
  end

endmodule

@@ tb/sv/uart_register_datagram_crc8_tb.sv @@
// Testbench top for the UART register link: stimulus, idling, node address setup, verdict.
module uart_register_datagram_crc8_tb;
  import urdc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Request code the block takes and drops
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  // Cycles to let a request that yields nothing work through the pipeline
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 10;
  localparam int CYCLE_LIMIT   = 200000;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [1:0]  in_req_type;
  logic [6:0]  in_reg_index;
  logic [31:0] in_write_data;
  logic [7:0]  in_rx_byte;
  logic        empty;
  logic        pop;
  logic        out_result_kind;
  logic [7:0]  out_tx_byte;
  logic        out_last;
  logic [31:0] out_read_value;
  logic        out_reply_valid;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_node_address;

  int          fail_count;
  int          outstanding;

  // Stimulus bookkeeping
  int          sent_count;   // accepted transactions that the block acts on
  logic [2:0]  line_bytes;   // received bytes modulo the reply length
  logic        quiet;        // last part of the run: no idling on either side
  logic        calm;         // sender stretch without gaps

  uart_register_datagram_crc8 dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_req_type      (in_req_type),
    .in_reg_index     (in_reg_index),
    .in_write_data    (in_write_data),
    .in_rx_byte       (in_rx_byte),
    .empty            (empty),
    .pop              (pop),
    .out_result_kind  (out_result_kind),
    .out_tx_byte      (out_tx_byte),
    .out_last         (out_last),
    .out_read_value   (out_read_value),
    .out_reply_valid  (out_reply_valid),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_node_address (cfg_node_address)
  );

  uart_register_datagram_crc8_checker frame_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_req_type      (in_req_type),
    .in_reg_index     (in_reg_index),
    .in_write_data    (in_write_data),
    .in_rx_byte       (in_rx_byte),
    .empty            (empty),
    .pop              (pop),
    .out_result_kind  (out_result_kind),
    .out_tx_byte      (out_tx_byte),
    .out_last         (out_last),
    .out_read_value   (out_read_value),
    .out_reply_valid  (out_reply_valid),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_node_address (cfg_node_address),
    .fail_count       (fail_count),
    .outstanding      (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: well beyond the slowest correct run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  // Result side: pop in random runs, with stall bursts of random length
  initial begin
    pop <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      pop <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Mostly random words, now and then the all-zero and all-one extremes
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Present one transaction, hold it until accepted, then maybe idle for a random stretch
  task automatic put_item(input logic [1:0] req, input logic [6:0] idx,
                          input logic [31:0] data, input logic [7:0] rxb);
    in_req_type   <= req;
    in_reg_index  <= idx;
    in_write_data <= data;
    in_rx_byte    <= rxb;
    push          <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    if (req != REQ_UNUSED) sent_count++;
    if (req == REQ_RX) line_bytes = line_bytes + 3'd1;
    if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Write or read request with random content
  task automatic put_request();
    put_item($urandom_range(0, 1) ? REQ_READ : REQ_WRITE, 7'($urandom_range(0, 127)),
             pick_word(), 8'($urandom_range(0, 255)));
  endtask

  // Feed one 8-byte reply; realign the byte stream first if a stray byte broke it.
  // Optionally corrupt the CRC byte, and slip a request in after byte mix_at.
  task automatic send_reply(input logic [7:0] addr, input logic [7:0] reg_byte,
                            input logic [31:0] word, input logic corrupt, input int mix_at);
    logic [7:0] reply_bytes [0:7];
    int         i;
    while (line_bytes != 3'd0)
      put_item(REQ_RX, 7'($urandom_range(0, 127)), $urandom(), 8'($urandom_range(0, 255)));
    reply_bytes[0] = SyncByte;
    reply_bytes[1] = addr;
    reply_bytes[2] = reg_byte;
    reply_bytes[3] = word[31:24];
    reply_bytes[4] = word[23:16];
    reply_bytes[5] = word[15:8];
    reply_bytes[6] = word[7:0];
    reply_bytes[7] = CrcInit;
    for (i = 0; i < 7; i++) reply_bytes[7] = urdc_pkg::crc8_feed(reply_bytes[7], reply_bytes[i]);
    if (corrupt) reply_bytes[7] = reply_bytes[7] ^ (8'h01 << $urandom_range(0, 7));
    for (i = 0; i < 8; i++) begin
      put_item(REQ_RX, 7'($urandom_range(0, 127)), $urandom(), reply_bytes[i]);
      if (i == mix_at) put_request();
    end
  endtask

  // Hold the sender until every expected result has come, then let the pipeline drain
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write node_address over the configuration channel
  task automatic set_node(input logic [7:0] node);
    cfg_node_address <= node;
    cfg_valid        <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic: mostly requests and well-formed replies, some noise
  task automatic random_phase(input int count);
    int target;
    int roll;
    target = sent_count + count;
    while (sent_count < target) begin
      if ($urandom_range(0, 9) == 0) calm = ~calm;
      roll = $urandom_range(0, 99);
      if (roll < 22)
        put_item(REQ_WRITE, 7'($urandom_range(0, 127)), pick_word(),
                 8'($urandom_range(0, 255)));
      else if (roll < 40)
        put_item(REQ_READ, 7'($urandom_range(0, 127)), pick_word(),
                 8'($urandom_range(0, 255)));
      else if (roll < 88)
        send_reply(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : ReplyAddress,
                   8'($urandom_range(0, 255)), pick_word(), $urandom_range(0, 4) == 0,
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : -1);
      else if (roll < 94)
        // stray byte: throws the reply framing off until realigned
        put_item(REQ_RX, 7'($urandom_range(0, 127)), $urandom(),
                 8'($urandom_range(0, 255)));
      else
        put_item(REQ_UNUSED, 7'($urandom_range(0, 127)), $urandom(),
                 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    sent_count = 0;
    line_bytes = '0;
    quiet      = 1'b0;
    calm       = 1'b0;
    rst_n            <= 1'b0;
    push             <= 1'b0;
    in_req_type      <= REQ_WRITE;
    in_reg_index     <= '0;
    in_write_data    <= '0;
    in_rx_byte       <= '0;
    cfg_valid        <= 1'b0;
    cfg_node_address <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: field extremes, both request kinds, the dropped code,
    // a request in the middle of a reply, a good reply and a bad-CRC reply
    set_node(8'h00);
    put_item(REQ_WRITE, 7'h00, 32'h0000_0000, 8'h00);
    put_item(REQ_WRITE, 7'h7F, 32'hFFFF_FFFF, 8'hFF);
    put_item(REQ_READ, 7'h00, 32'hFFFF_FFFF, 8'hFF);
    put_item(REQ_READ, 7'h7F, 32'h0000_0000, 8'h00);
    put_item(REQ_UNUSED, 7'h7F, 32'hFFFF_FFFF, 8'hFF);
    send_reply(ReplyAddress, 8'h00, 32'hFF00_FF00, 1'b0, 4);
    send_reply(ReplyAddress, 8'hFF, 32'h00FF_00FF, 1'b1, -1);
    settle();

    // Random phases at different node addresses, each one drained before the next write
    set_node(8'hFF);
    random_phase(120);
    settle();
    set_node(8'($urandom_range(1, 254)));
    random_phase(120);
    settle();

    // Last part: no idling on either side
    set_node(8'($urandom_range(0, 255)));
    quiet = 1'b1;
    calm  = 1'b1;
    random_phase(110);
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && outstanding == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
